[sv/f2c_pkg.sv]
package f2c_pkg;

  localparam int unsigned MaxWaypoints = 256;
  localparam int unsigned AddrW        = $clog2(MaxWaypoints);
  localparam int unsigned CountW       = $clog2(MaxWaypoints + 1);
  // one table word: x, y, s
  localparam int unsigned WordW        = 32 + 32 + 31;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [7:0]         wp_index;
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic [30:0]        wp_s;
    logic [30:0]        query_s;
    logic signed [31:0] query_d;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [7:0]         segment_start;
    logic               zero_length;
  } res_t;

endpackage

[sv/f2c_ram.sv]
module f2c_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/frenet_to_cartesian.sv]
// Frenet to Cartesian converter over a closed loop of waypoints.
// Request channel (in_valid_i/in_ready_o, in_req_i): a load request writes
// one waypoint (x, y, s) into the table and gives no result; a query request
// gives one result (position, segment start, zero-length flag).
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i) sets the number of
// waypoints in use; it is always ready and is to be written while idle (not enforced).
// Result channel: out_valid_o/out_ready_i, out_res_o, held in an output
// register so the next request is taken while a result waits.
// A load leaves the block idle and ready for the next request. A query runs
// on one sequencer around a single shared multiplier: a scan of the table
// entries, normalize shifting, 32 square-root steps, two 62-step restoring
// divides and 6 multiply-accumulate and rounding steps.
// in_ready_o is low while a query runs. If the result register is still
// full at the end, the sequencer waits until it is taken.
// Reset clears the control state and sets the count to 256; the table
// holds no values until loaded.
module frenet_to_cartesian (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  f2c_pkg::req_t                in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output f2c_pkg::res_t                out_res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [f2c_pkg::CountW-1:0]   cfg_data_i
);
  import f2c_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHK, S_SEL, S_RDN, S_DIFF, S_NORM, S_SQ,
    S_SQRT, S_DINIT, S_DIV, S_ACC, S_DONE
  } state_e;

  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  state_e             state_q;
  logic [2:0]         step_q;
  logic [5:0]         cnt_q;
  logic [CountW-1:0]  count_q, n_q, idx_q;
  logic [30:0]        qs_q, s0_q;
  logic signed [31:0] qd_q, x0_q, y0_q, ux_q, uy_q, px_q, py_q;
  logic [AddrW-1:0]   prev_q, next_q;
  logic               sx_q, sy_q, zero_q, div_b_q, out_valid_q;
  logic [32:0]        a_q, b_q, rem_q;
  logic [63:0]        v_q, res_q, bit_q;
  logic [31:0]        len_q;
  logic [61:0]        num_q;
  logic signed [65:0] acc_q;
  res_t               out_q;

  logic               load_we;
  logic [AddrW-1:0]   raddr;
  logic [WordW-1:0]   rword;
  logic signed [31:0] rd_x, rd_y;
  logic [30:0]        rd_s;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign load_we     = in_valid_i && in_ready_o && (in_req_i.req_type == REQ_LOAD);

  assign rd_x = rword[WordW-1 -: 32];
  assign rd_y = rword[WordW-33 -: 32];
  assign rd_s = rword[30:0];

  // segment ends
  logic [CountW-1:0] prev_n, next_n;
  always_comb begin
    prev_n = (idx_q == '0) ? '0 : idx_q - CountW'(1);
    next_n = (prev_n + CountW'(1) >= n_q) ? '0 : prev_n + CountW'(1);
  end

  always_comb begin
    case (state_q)
      S_SCAN:  raddr = idx_q[AddrW-1:0];
      S_SEL:   raddr = prev_n[AddrW-1:0];
      S_RDN:   raddr = next_q;
      default: raddr = idx_q[AddrW-1:0];
    endcase
  end

  f2c_ram #(
    .Width (WordW),
    .Depth (MaxWaypoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (in_req_i.wp_index[AddrW-1:0]),
    .wdata_i ({in_req_i.wp_x, in_req_i.wp_y, in_req_i.wp_s}),
    .raddr_i (raddr),
    .rdata_o (rword)
  );

  // segment vector
  logic signed [32:0] dx, dy;
  logic [32:0]        m_max;
  assign dx    = {rd_x[31], rd_x} - {x0_q[31], x0_q};
  assign dy    = {rd_y[31], rd_y} - {y0_q[31], y0_q};
  assign m_max = (a_q > b_q) ? a_q : b_q;

  // square-root digit step
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = res_q + bit_q;
  assign sq_ge = (v_q >= sq_t);

  // restoring divide step
  logic [32:0] dv_r, rem_d;
  logic        dv_ge;
  logic [61:0] num_d, num_init;
  logic [31:0] mag;
  logic signed [31:0] u_d;
  assign dv_r     = {rem_q[31:0], num_q[61]};
  assign dv_ge    = (dv_r >= {1'b0, len_q});
  assign rem_d    = dv_ge ? dv_r - {1'b0, len_q} : dv_r;
  assign num_d    = {num_q[60:0], dv_ge};
  assign num_init = {1'b0, (div_b_q ? b_q[30:0] : a_q[30:0]), 30'd0}
                  + {31'd0, len_q[31:1]};
  assign mag      = (num_d > 62'(OneQ30)) ? OneQ30 : num_d[31:0];
  assign u_d      = (div_b_q ? sy_q : sx_q) ? -$signed(mag) : $signed(mag);

  // shared multiplier
  logic signed [32:0] along, mul_a, mul_b;
  logic signed [65:0] prod;
  assign along = $signed({2'b00, qs_q}) - $signed({2'b00, s0_q});

  always_comb begin
    mul_a = along;
    mul_b = {ux_q[31], ux_q};
    case (state_q)
      S_SQ: begin
        mul_a = (step_q == 3'd0) ? $signed(a_q) : $signed(b_q);
        mul_b = mul_a;
      end
      S_ACC: begin
        case (step_q)
          3'd0:    begin mul_a = along;                mul_b = {ux_q[31], ux_q}; end
          3'd1:    begin mul_a = {qd_q[31], qd_q};     mul_b = {uy_q[31], uy_q}; end
          3'd3:    begin mul_a = along;                mul_b = {uy_q[31], uy_q}; end
          3'd4:    begin mul_a = {qd_q[31], qd_q};     mul_b = {ux_q[31], ux_q}; end
          default: begin mul_a = along;                mul_b = {ux_q[31], ux_q}; end
        endcase
      end
      default: begin
        mul_a = along;
        mul_b = {ux_q[31], ux_q};
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // round half up from Q.42 to Q20.12, then saturate
  logic signed [65:0] rnd_t;
  logic signed [35:0] rnd_q;
  logic signed [31:0] sat;
  always_comb begin
    rnd_t = acc_q + 66'sd536870912;
    rnd_q = 36'(rnd_t >>> 30);
    if (rnd_q > 36'sh0_7FFF_FFFF) begin
      sat = 32'sh7FFF_FFFF;
    end else if (rnd_q < -36'sh0_8000_0000) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = rnd_q[31:0];
    end
  end

  logic signed [65:0] base_x, base_y;
  assign base_x = {{4{x0_q[31]}}, x0_q, 30'd0};
  assign base_y = {{4{y0_q[31]}}, y0_q, 30'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      count_q     <= CountW'(MaxWaypoints);
      n_q         <= CountW'(2);
      idx_q       <= '0;
      qs_q        <= '0;
      s0_q        <= '0;
      qd_q        <= '0;
      x0_q        <= '0;
      y0_q        <= '0;
      ux_q        <= '0;
      uy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      prev_q      <= '0;
      next_q      <= '0;
      sx_q        <= 1'b0;
      sy_q        <= 1'b0;
      zero_q      <= 1'b0;
      div_b_q     <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      rem_q       <= '0;
      v_q         <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      len_q       <= '0;
      num_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      // S_DONE reloads the result register itself
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_req_i.req_type == REQ_QUERY) begin
            qs_q  <= in_req_i.query_s;
            qd_q  <= in_req_i.query_d;
            idx_q <= '0;
            if (count_q < CountW'(2)) begin
              n_q <= CountW'(2);
            end else if (count_q > CountW'(MaxWaypoints)) begin
              n_q <= CountW'(MaxWaypoints);
            end else begin
              n_q <= count_q;
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          state_q <= (idx_q < n_q) ? S_CHK : S_SEL;
        end
        S_CHK: begin
          if (qs_q > rd_s) begin
            idx_q   <= idx_q + CountW'(1);
            state_q <= S_SCAN;
          end else begin
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          prev_q  <= prev_n[AddrW-1:0];
          next_q  <= next_n[AddrW-1:0];
          state_q <= S_RDN;
        end
        S_RDN: begin
          x0_q    <= rd_x;
          y0_q    <= rd_y;
          s0_q    <= rd_s;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          sx_q   <= dx[32];
          sy_q   <= dy[32];
          a_q    <= dx[32] ? 33'(-dx) : 33'(dx);
          b_q    <= dy[32] ? 33'(-dy) : 33'(dy);
          step_q <= '0;
          if (dx == '0 && dy == '0) begin
            zero_q  <= 1'b1;
            ux_q    <= OneQ30;
            uy_q    <= '0;
            state_q <= S_ACC;
          end else begin
            zero_q  <= 1'b0;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          // bring max(|dx|,|dy|) into [2^30, 2^31)
          if (m_max < 33'h0_4000_0000) begin
            a_q <= {a_q[31:0], 1'b0};
            b_q <= {b_q[31:0], 1'b0};
          end else if (m_max[32:31] != 2'b00) begin
            a_q <= {1'b0, a_q[32:1]};
            b_q <= {1'b0, b_q[32:1]};
          end else begin
            step_q  <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_q == 3'd0) begin
            acc_q  <= prod;
            step_q <= 3'd1;
          end else begin
            v_q     <= 64'(acc_q + prod);
            res_q   <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            v_q   <= v_q - sq_t;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            len_q   <= sq_ge ? 32'((res_q >> 1) + bit_q) : 32'(res_q >> 1);
            div_b_q <= 1'b0;
            state_q <= S_DINIT;
          end
        end
        S_DINIT: begin
          num_q   <= num_init;
          rem_q   <= '0;
          cnt_q   <= 6'd61;
          state_q <= S_DIV;
        end
        S_DIV: begin
          num_q <= num_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            if (div_b_q) begin
              uy_q    <= u_d;
              step_q  <= '0;
              state_q <= S_ACC;
            end else begin
              ux_q    <= u_d;
              div_b_q <= 1'b1;
              state_q <= S_DINIT;
            end
          end
        end
        S_ACC: begin
          step_q <= step_q + 3'd1;
          case (step_q)
            3'd0:    acc_q <= base_x + prod;
            3'd1:    acc_q <= acc_q + prod;
            3'd2:    px_q  <= sat;
            3'd3:    acc_q <= base_y + prod;
            3'd4:    acc_q <= acc_q - prod;
            default: begin
              py_q    <= sat;
              state_q <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.pos_x         <= px_q;
            out_q.pos_y         <= py_q;
            out_q.segment_start <= prev_q;
            out_q.zero_length   <= zero_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= n_q)
    else $error("scan index beyond waypoint count");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.req_type == REQ_QUERY |=> !in_ready_o)
    else $error("ready while query in flight");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC |-> (ux_q <= OneQ30 && ux_q >= -OneQ30 &&
                          uy_q <= OneQ30 && uy_q >= -OneQ30))
    else $error("direction component out of range");
`endif

endmodule

[bench/tb_frenet_to_cartesian.sv]
module tb_frenet_to_cartesian;
  import f2c_pkg::*;

  class f2c_scoreboard;
    logic signed [31:0] x_tab[MaxWaypoints];
    logic signed [31:0] y_tab[MaxWaypoints];
    logic [30:0]        s_tab[MaxWaypoints];
    int unsigned        count_reg;
    res_t               expected_pos_q[$];
    int                 errors;

    function new();
      count_reg = 256;
      errors = 0;
    endfunction

    function void set_count(int unsigned v);
      count_reg = v;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // round half up from Q.42 to Q20.12, then clamp
    function logic signed [31:0] round_sat(longint v);
      longint q;
      q = (v + (64'sd1 <<< 29)) >>> 30;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function res_t convert(logic [30:0] qs, logic signed [31:0] qd);
      int unsigned n, i, prev, nxt;
      longint dx, dy, ux, uy, along, accx, accy;
      longint unsigned a, b, m, len, ma, mb;
      res_t r;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > MaxWaypoints) n = MaxWaypoints;
      i = 0;
      while (i < n && qs > s_tab[i]) i++;
      prev = (i == 0) ? 0 : i - 1;
      nxt = (prev + 1 >= n) ? 0 : prev + 1;
      dx = longint'(x_tab[nxt]) - longint'(x_tab[prev]);
      dy = longint'(y_tab[nxt]) - longint'(y_tab[prev]);
      r.zero_length = (dx == 0 && dy == 0);
      if (r.zero_length) begin
        ux = 64'sd1 << 30;
        uy = 0;
      end else begin
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        m = (a > b) ? a : b;
        while (m < (64'd1 << 30)) begin a <<= 1; b <<= 1; m <<= 1; end
        while (m >= (64'd1 << 31)) begin a >>= 1; b >>= 1; m >>= 1; end
        len = isqrt(a * a + b * b);
        ma = ((a << 30) + (len >> 1)) / len;
        mb = ((b << 30) + (len >> 1)) / len;
        if (ma > (64'd1 << 30)) ma = 64'd1 << 30;
        if (mb > (64'd1 << 30)) mb = 64'd1 << 30;
        ux = (dx < 0) ? -longint'(ma) : longint'(ma);
        uy = (dy < 0) ? -longint'(mb) : longint'(mb);
      end
      along = longint'({1'b0, qs}) - longint'({1'b0, s_tab[prev]});
      accx = (longint'(x_tab[prev]) <<< 30) + along * ux + longint'(qd) * uy;
      accy = (longint'(y_tab[prev]) <<< 30) + along * uy - longint'(qd) * ux;
      r.pos_x = round_sat(accx);
      r.pos_y = round_sat(accy);
      r.segment_start = prev[7:0];
      return r;
    endfunction

    function void note_request(req_t r);
      if (r.req_type == REQ_LOAD) begin
        x_tab[r.wp_index] = r.wp_x;
        y_tab[r.wp_index] = r.wp_y;
        s_tab[r.wp_index] = r.wp_s;
      end else begin
        expected_pos_q = {expected_pos_q, convert(r.query_s, r.query_d)};
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_pos_q.size() == 0) begin
        $error("result with no query pending");
        errors++;
        return;
      end
      exp_r = expected_pos_q.pop_front();
      if (got.pos_x !== exp_r.pos_x) begin
        $error("pos_x: expected %0d, got %0d", exp_r.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== exp_r.pos_y) begin
        $error("pos_y: expected %0d, got %0d", exp_r.pos_y, got.pos_y);
        errors++;
      end
      if (got.segment_start !== exp_r.segment_start) begin
        $error("segment_start: expected %0d, got %0d", exp_r.segment_start,
               got.segment_start);
        errors++;
      end
      if (got.zero_length !== exp_r.zero_length) begin
        $error("zero_length: expected %0d, got %0d", exp_r.zero_length,
               got.zero_length);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 800;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  req_t              in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  res_t              out_res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_data_i;

  f2c_scoreboard sb;
  bit            stall_on;
  int unsigned   cycles;

  frenet_to_cartesian dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_res_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_count(int'(cfg_data_i));
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !(stall_on && $urandom_range(99) < 25);
  end

  task automatic send(req_t r);
    if (stall_on && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic req_t noise_fields();
    req_t r;
    r.wp_index = 8'($urandom);
    r.wp_x = $urandom;
    r.wp_y = $urandom;
    r.wp_s = 31'($urandom);
    r.query_s = 31'($urandom);
    r.query_d = $urandom;
    return r;
  endfunction

  task automatic load_wp(int unsigned idx, logic signed [31:0] x, logic signed [31:0] y,
                         logic [30:0] s);
    req_t r;
    r = noise_fields();
    r.req_type = REQ_LOAD;
    r.wp_index = 8'(idx);
    r.wp_x = x;
    r.wp_y = y;
    r.wp_s = s;
    send(r);
  endtask

  task automatic query(logic [30:0] s, logic signed [31:0] d);
    req_t r;
    r = noise_fields();
    r.req_type = REQ_QUERY;
    r.query_s = s;
    r.query_d = d;
    send(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_pos_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_count(int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CountW'(v);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ascending track of n points; wide mode spans the full coordinate range
  task automatic load_track(int unsigned n, bit wide, output logic [30:0] last_s);
    logic signed [31:0] x, y;
    longint s;
    s = $urandom_range(0, 1 << 20);
    x = $urandom_range(0, 1 << 24) - (1 << 23);
    y = $urandom_range(0, 1 << 24) - (1 << 23);
    for (int unsigned i = 0; i < n; i++) begin
      load_wp(i, x, y, s[30:0]);
      last_s = s[30:0];
      if ($urandom_range(9) != 0) begin
        if (wide) begin
          x = $urandom;
          y = $urandom;
        end else begin
          x += $signed($urandom_range(0, 1 << 22)) - (1 << 21);
          y += $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        end
      end
      if ($urandom_range(15) != 0) s += $urandom_range(0, 1 << 22);
      if (s > 64'h7fff_ffff) s = 64'h7fff_ffff;
    end
  endtask

  initial begin
    int unsigned counts[14];
    int unsigned n;
    logic [30:0] last_s;
    logic [30:0] qs;
    logic signed [31:0] qd;
    sb = new();
    stall_on = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // queries only read entries below the count, which are always loaded first
    write_count(4);

    // short loop: a real segment, a zero-length one, one spanning the extremes
    load_wp(0, 0, 0, 31'(100 << 12));
    load_wp(1, 10 << 12, 0, 31'(200 << 12));
    load_wp(2, 10 << 12, 0, 31'(300 << 12));
    load_wp(3, 32'sh7fff_ffff, 32'sh8000_0000, 31'(400 << 12));
    query(31'd0, 0);                           // below first waypoint
    query(31'(150 << 12), 0);
    query(31'(150 << 12), 32'sh7fff_ffff);
    query(31'(150 << 12), 32'sh8000_0000);
    query(31'(200 << 12), 5 << 12);            // exactly on a waypoint
    query(31'(250 << 12), -(3 << 12));         // zero-length segment
    query(31'(350 << 12), 32'sh7fff_ffff);
    query(31'h7fff_ffff, 32'sh8000_0000);      // past the last, wraps to entry 0
    query(31'h7fff_ffff, 0);
    wait_idle();

    counts = '{2, 256, 3, 0, 1, 511, 7, 5, 8, 2, 16, 6, 40, 4};
    for (int p = 0; p < 14; p++) begin
      stall_on = (p != 3 && p != 4);
      write_count(counts[p]);
      n = counts[p] < 2 ? 2 : (counts[p] > MaxWaypoints ? MaxWaypoints : counts[p]);
      load_track(n, (p % 3) == 1, last_s);
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(9) == 0) begin
          // stray load: reuse the table slot with arbitrary content
          load_wp($urandom_range(0, MaxWaypoints - 1), $urandom, $urandom,
                  31'($urandom));
        end else begin
          qs = ($urandom_range(4) == 0) ? 31'($urandom)
                                       : 31'($urandom_range(0, last_s + (1 << 20)));
          qd = ($urandom_range(3) == 0) ? 32'($urandom)
                                       : 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
          query(qs, qd);
        end
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_pos_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
